// File: hdl/steq_pkg.sv
// steq_pkg: shared types and constants for the sorted timer event queue
// no dependencies; used by the top level and the testbench
package steq_pkg;

  localparam int CAPACITY    = 32;
  localparam int MAX_RESULTS = 32;
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int USEC_ONE_SEC = 1000000;

  typedef enum logic [2:0] {
    OP_INSERT     = 3'd0,
    OP_RM_OWNER   = 3'd1,
    OP_RM_OWNKIND = 3'd2,
    OP_QUERY      = 3'd3,
    OP_EXPIRE     = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_NOTHING = 2'd2
  } status_t;

  typedef struct packed {
    logic [2:0]  operation;
    logic [31:0] deadline_sec;
    logic [19:0] deadline_usec;
    logic [7:0]  event_kind;
    logic [15:0] owner_id;
    logic [31:0] now_sec;
    logic [19:0] now_usec;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] wait_sec;
    logic [19:0] wait_usec;
    logic [7:0]  due_kind;
    logic [15:0] due_owner;
    logic [5:0]  removed_count;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [51:0] deadline;
    logic [7:0]  kind;
    logic [15:0] owner;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// File: hdl/steq_ram.sv
// steq_ram: simple dual port ram, one write and one registered read port
// generic, no package dependency
module steq_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 76,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/sorted_timer_event_queue.sv
// sorted_timer_event_queue: top level, sequencer around one entry ram
// depends on steq_pkg and steq_ram
//
// usage:
// - input channel in_valid / in_stall / in_data carries one operation item
//   (insert, remove by owner, remove by owner and type, query, expire)
// - result channel out_valid / out_stall / out_data; every operation but an
//   unknown code gives at least one result, the final one has last set
// - entries live in one ram (registered read port), kept sorted by deadline
// - in_stall is high from acceptance until the sequencer is back in idle:
//   after the final result is loaded into the output register, and for expire
//   after the store has been compacted; the output register parts the result
//   side, so the next item is taken while the final result still waits
// - every ram walk steps through a read state then an evaluate/write state
//   per entry; a full store on insert and an empty store on query are
//   answered without a ram walk
// - a stalled receiver holds the sequencer in its send step, nothing is lost
// - reset clears the entry count; no clearing pass, entries above the count
//   are never read
module sorted_timer_event_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  steq_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output steq_pkg::out_item_t out_data
);

  localparam int IDX_W = steq_pkg::IDX_W;
  localparam int CNT_W = steq_pkg::CNT_W;

  typedef enum logic [3:0] {
    S_IDLE, S_INS_RD, S_INS_EV, S_RM_RD, S_RM_EV, S_Q_EV,
    S_EX_RD, S_EX_EV, S_SH_RD, S_SH_WR, S_SEND
  } state_t;

  state_t              state_r, state_nxt, ret_r, ret_nxt;
  steq_pkg::in_item_t  cur_r, cur_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [CNT_W-1:0]    idx_r, idx_nxt;    // insert position, read index, shift source
  logic [CNT_W-1:0]    kept_r, kept_nxt;  // compaction / shift destination
  logic [23:0]         pend_r, pend_nxt;  // expired event waiting for its last flag
  logic                have_pend_r, have_pend_nxt;
  steq_pkg::out_item_t res_r, res_nxt;
  steq_pkg::out_item_t out_r, out_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr, ram_raddr;
  steq_pkg::entry_t    ram_wdata, ram_rdata;

  logic [51:0]         new_dl, now_t;
  steq_pkg::entry_t    new_ent;
  logic                borrow;
  logic [20:0]         wu_full;
  logic [CNT_W-1:0]    dropped;
  logic                tag_match;

  steq_ram #(
    .DEPTH (steq_pkg::CAPACITY),
    .WIDTH (steq_pkg::ENTRY_W),
    .AW    (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign new_dl  = {cur_r.deadline_sec, cur_r.deadline_usec};
  assign now_t   = {cur_r.now_sec, cur_r.now_usec};
  assign new_ent = '{deadline: new_dl, kind: cur_r.event_kind, owner: cur_r.owner_id};
  assign borrow  = (ram_rdata.deadline[19:0] < cur_r.now_usec);
  assign wu_full = borrow ?
                   21'({1'b0, ram_rdata.deadline[19:0]}) + 21'(steq_pkg::USEC_ONE_SEC)
                   - {1'b0, cur_r.now_usec}
                   : {1'b0, ram_rdata.deadline[19:0]} - {1'b0, cur_r.now_usec};
  assign dropped = cnt_r - kept_r;
  // owner always compared, type only for the owner and type removal
  assign tag_match = (ram_rdata.owner == cur_r.owner_id) &&
                     ((cur_r.operation == steq_pkg::OP_RM_OWNER) ||
                      (ram_rdata.kind == cur_r.event_kind));

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    cur_nxt       = cur_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    kept_nxt      = kept_r;
    pend_nxt      = pend_r;
    have_pend_nxt = have_pend_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    ram_we        = 1'b0;
    ram_waddr     = idx_r[IDX_W-1:0];
    ram_wdata     = ram_rdata;
    ram_raddr     = idx_r[IDX_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cur_nxt  = in_data;
          res_nxt  = '0;
          res_nxt.last = 1'b1;
          kept_nxt = '0;
          idx_nxt  = '0;
          have_pend_nxt = 1'b0;
          case (in_data.operation)
            steq_pkg::OP_INSERT: begin
              if (cnt_r == CNT_W'(steq_pkg::CAPACITY)) begin
                res_nxt.status = steq_pkg::ST_FULL;
                ret_nxt   = S_IDLE;
                state_nxt = S_SEND;
              end else begin
                idx_nxt   = cnt_r;
                state_nxt = S_INS_RD;
              end
            end
            steq_pkg::OP_RM_OWNER, steq_pkg::OP_RM_OWNKIND: state_nxt = S_RM_RD;
            steq_pkg::OP_QUERY: begin
              if (cnt_r == '0) begin
                res_nxt.status = steq_pkg::ST_NOTHING;
                ret_nxt   = S_IDLE;
                state_nxt = S_SEND;
              end else begin
                ram_raddr = '0;
                state_nxt = S_Q_EV;
              end
            end
            steq_pkg::OP_EXPIRE: state_nxt = S_EX_RD;
            default: state_nxt = S_IDLE;
          endcase
        end
      end

      // walk down from the top, moving later entries up one slot
      S_INS_RD: begin
        if (idx_r == '0) begin
          ram_we    = 1'b1;
          ram_waddr = '0;
          ram_wdata = new_ent;
          cnt_nxt   = cnt_r + 1'b1;
          ret_nxt   = S_IDLE;
          state_nxt = S_SEND;
        end else begin
          ram_raddr = IDX_W'(idx_r - 1'b1);
          state_nxt = S_INS_EV;
        end
      end
      S_INS_EV: begin
        ram_we = 1'b1;
        if (ram_rdata.deadline > new_dl) begin
          ram_wdata = ram_rdata;
          idx_nxt   = idx_r - 1'b1;
          state_nxt = S_INS_RD;
        end else begin
          ram_wdata = new_ent;
          cnt_nxt   = cnt_r + 1'b1;
          ret_nxt   = S_IDLE;
          state_nxt = S_SEND;
        end
      end

      // compaction: keep entries that do not match
      S_RM_RD: begin
        if (idx_r == cnt_r) begin
          cnt_nxt = kept_r;
          res_nxt.removed_count = (int'(dropped) > 63) ? 6'd63 : 6'(dropped);
          ret_nxt   = S_IDLE;
          state_nxt = S_SEND;
        end else begin
          state_nxt = S_RM_EV;
        end
      end
      S_RM_EV: begin
        if (!tag_match) begin
          ram_we    = 1'b1;
          ram_waddr = kept_r[IDX_W-1:0];
          kept_nxt  = kept_r + 1'b1;
        end
        idx_nxt   = idx_r + 1'b1;
        state_nxt = S_RM_RD;
      end

      S_Q_EV: begin
        if (ram_rdata.deadline > now_t) begin
          res_nxt.wait_sec  = ram_rdata.deadline[51:20] - cur_r.now_sec - 32'(borrow);
          res_nxt.wait_usec = wu_full[19:0];
        end
        ret_nxt   = S_IDLE;
        state_nxt = S_SEND;
      end

      // expire: one result behind the scan so the last flag is known
      S_EX_RD: begin
        if ((idx_r == cnt_r) || (int'(idx_r) == steq_pkg::MAX_RESULTS)) begin
          if (have_pend_r) begin
            res_nxt.due_kind  = pend_r[23:16];
            res_nxt.due_owner = pend_r[15:0];
            ret_nxt = S_SH_RD;
          end else begin
            res_nxt.status = steq_pkg::ST_NOTHING;
            ret_nxt = S_IDLE;
          end
          kept_nxt  = '0;
          state_nxt = S_SEND;
        end else begin
          state_nxt = S_EX_EV;
        end
      end
      S_EX_EV: begin
        if (ram_rdata.deadline <= now_t) begin
          pend_nxt      = {ram_rdata.kind, ram_rdata.owner};
          have_pend_nxt = 1'b1;
          idx_nxt       = idx_r + 1'b1;
          if (have_pend_r) begin
            res_nxt.due_kind  = pend_r[23:16];
            res_nxt.due_owner = pend_r[15:0];
            res_nxt.last      = 1'b0;
            ret_nxt   = S_EX_RD;
            state_nxt = S_SEND;
          end else begin
            state_nxt = S_EX_RD;
          end
        end else begin
          // first entry not yet due: the scan ends here
          if (have_pend_r) begin
            res_nxt.due_kind  = pend_r[23:16];
            res_nxt.due_owner = pend_r[15:0];
            ret_nxt = S_SH_RD;
          end else begin
            res_nxt.status = steq_pkg::ST_NOTHING;
            ret_nxt = S_IDLE;
          end
          kept_nxt  = '0;
          state_nxt = S_SEND;
        end
      end

      // close the gap left by expired entries
      S_SH_RD: begin
        if (idx_r == cnt_r) begin
          cnt_nxt   = kept_r;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_SH_WR;
        end
      end
      S_SH_WR: begin
        ram_we    = 1'b1;
        ram_waddr = kept_r[IDX_W-1:0];
        kept_nxt  = kept_r + 1'b1;
        idx_nxt   = idx_r + 1'b1;
        state_nxt = S_SH_RD;
      end

      S_SEND: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt       = res_nxt;
          out_valid_nxt = 1'b1;
          res_nxt       = '0;
          res_nxt.last  = 1'b1;
          state_nxt     = ret_r;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      cnt_r       <= '0;
      idx_r       <= '0;
      kept_r      <= '0;
      have_pend_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      kept_r      <= kept_nxt;
      have_pend_r <= have_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cur_r  <= cur_nxt;
    pend_r <= pend_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(cnt_r) <= steq_pkg::CAPACITY)
    else $error("entry count above capacity");

  a_wr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (int'(ram_waddr) <= int'(cnt_r)))
    else $error("ram write beyond stored entries");

  a_send_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEND && (!out_valid_r || !out_stall)) |=> out_valid_r)
    else $error("result not loaded into output register");
`endif

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for sorted_timer_event_queue, directed then random items
// depends on steq_pkg and the sorted_timer_event_queue rtl
module tb;

  // codes outside the defined operations
  localparam logic [2:0] OP_UNKNOWN_LO = 3'd5;
  localparam logic [2:0] OP_UNKNOWN_HI = 3'd7;

  // scoreboard: keeps its own sorted copy of the timer store and a queue of
  // results the block owes us
  class timer_queue_board;
    logic [51:0] dl_q[$];
    logic [7:0]  kind_q[$];
    logic [15:0] owner_q[$];
    steq_pkg::out_item_t owed[$];
    int          errors;

    function automatic steq_pkg::out_item_t blank();
      steq_pkg::out_item_t r;
      r = '0;
      r.last = 1'b1;
      return r;
    endfunction

    // work out the results of one accepted item and queue them
    function void note_item(steq_pkg::in_item_t it);
      logic [51:0] dl, now;
      logic [31:0] ws;
      logic [19:0] wu, eu;
      steq_pkg::out_item_t r;
      int          pos, due, n;
      dl  = {it.deadline_sec, it.deadline_usec};
      now = {it.now_sec, it.now_usec};
      r = blank();
      case (it.operation)
        steq_pkg::OP_INSERT: begin
          if (dl_q.size() >= steq_pkg::CAPACITY) begin
            r.status = steq_pkg::ST_FULL;
          end else begin
            pos = 0;
            while (pos < dl_q.size() && dl_q[pos] <= dl) pos++;
            dl_q.insert(pos, dl);
            kind_q.insert(pos, it.event_kind);
            owner_q.insert(pos, it.owner_id);
            r.status = steq_pkg::ST_OK;
          end
          owed.push_back(r);
        end
        steq_pkg::OP_RM_OWNER, steq_pkg::OP_RM_OWNKIND: begin
          n = 0;
          for (int i = dl_q.size() - 1; i >= 0; i--) begin
            if (owner_q[i] == it.owner_id &&
                (it.operation == steq_pkg::OP_RM_OWNER || kind_q[i] == it.event_kind)) begin
              dl_q.delete(i); kind_q.delete(i); owner_q.delete(i);
              n++;
            end
          end
          r.removed_count = (n > 63) ? 6'd63 : n[5:0];
          owed.push_back(r);
        end
        steq_pkg::OP_QUERY: begin
          if (dl_q.size() == 0) begin
            r.status = steq_pkg::ST_NOTHING;
          end else if (dl_q[0] > now) begin
            ws = dl_q[0][51:20] - it.now_sec;
            eu = dl_q[0][19:0];
            if (eu < it.now_usec) begin
              ws = ws - 32'd1;
              wu = eu + 20'(steq_pkg::USEC_ONE_SEC) - it.now_usec;
            end else begin
              wu = eu - it.now_usec;
            end
            r.wait_sec  = ws;
            r.wait_usec = wu;
          end
          owed.push_back(r);
        end
        steq_pkg::OP_EXPIRE: begin
          due = 0;
          while (due < dl_q.size() && due < steq_pkg::MAX_RESULTS && dl_q[due] <= now)
            due++;
          if (due == 0) begin
            r.status = steq_pkg::ST_NOTHING;
            owed.push_back(r);
          end
          for (int i = 0; i < due; i++) begin
            r = blank();
            r.due_kind  = kind_q[0];
            r.due_owner = owner_q[0];
            r.last      = (i + 1 == due);
            owed.push_back(r);
            dl_q.delete(0); kind_q.delete(0); owner_q.delete(0);
          end
        end
        default: ;  // unknown codes change nothing
      endcase
    endfunction

    task check_result(steq_pkg::out_item_t got);
      steq_pkg::out_item_t w;
      if (owed.size() == 0) begin
        report_mismatch("result with nothing expected");
        return;
      end
      w = owed.pop_front();
      if (got.status !== w.status) report_mismatch("status");
      if (got.wait_sec !== w.wait_sec) report_mismatch("wait_sec");
      if (got.wait_usec !== w.wait_usec) report_mismatch("wait_usec");
      if (got.due_kind !== w.due_kind) report_mismatch("due_kind");
      if (got.due_owner !== w.due_owner) report_mismatch("due_owner");
      if (got.removed_count !== w.removed_count) report_mismatch("removed_count");
      if (got.last !== w.last) report_mismatch("last");
    endtask

    task report_mismatch(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  steq_pkg::in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  steq_pkg::out_item_t out_data;

  timer_queue_board board = new();
  int  idle_cycles = 0;
  logic [31:0] clock_sec = 32'd1000;   // moving notion of "now" for random items
  logic [15:0] owner_pool[4] = '{16'h0000, 16'h0001, 16'hffff, 16'h1234};

  sorted_timer_event_queue dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  // accept on rising edge: check results, note inputs, watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) board.check_result(out_data);
      if (in_valid && !in_stall) board.note_item(in_data);
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // receiver stall pattern: runs of ready broken by random stalls
  initial begin
    @(posedge rst_n);
    forever begin
      repeat (gap_len()) @(negedge clk);
      out_stall <= 1'b1;
      repeat (gap_len()) @(negedge clk);
      out_stall <= 1'b0;
    end
  end

  // present one item and hold it until it is taken
  task automatic send_item(steq_pkg::in_item_t it);
    @(negedge clk);
    in_data  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic send_op(logic [2:0] op, logic [31:0] ds, logic [19:0] du, logic [7:0] k,
                         logic [15:0] o, logic [31:0] ns, logic [19:0] nu);
    steq_pkg::in_item_t it;
    it = '{operation: op, deadline_sec: ds, deadline_usec: du, event_kind: k,
           owner_id: o, now_sec: ns, now_usec: nu};
    send_item(it);
  endtask

  task automatic drain();
    while (board.owed.size() != 0) @(posedge clk);
  endtask

  // random item biased toward a live store: deadlines near the moving clock
  task automatic send_random();
    steq_pkg::in_item_t it;
    int sel;
    it = '0;
    sel = $urandom_range(0, 99);
    it.event_kind = 8'($urandom_range(0, 3));
    it.owner_id   = owner_pool[2'($urandom_range(0, 3))];
    it.now_sec    = clock_sec;
    it.now_usec   = 20'($urandom_range(0, 999999));
    it.deadline_sec  = clock_sec + 32'($urandom_range(0, 6));
    it.deadline_usec = ($urandom_range(0, 3) == 0) ? it.now_usec
                                                   : 20'($urandom_range(0, 999999));
    if (sel < 45) it.operation = steq_pkg::OP_INSERT;
    else if (sel < 55) it.operation = steq_pkg::OP_RM_OWNER;
    else if (sel < 63) it.operation = steq_pkg::OP_RM_OWNKIND;
    else if (sel < 75) it.operation = steq_pkg::OP_QUERY;
    else if (sel < 92) it.operation = steq_pkg::OP_EXPIRE;
    else begin
      // noise: raw random fields, any code including the unknown ones
      it = $bits(steq_pkg::in_item_t)'({$urandom, $urandom, $urandom, $urandom, $urandom});
      it.operation = 3'($urandom_range(0, 7));
    end
    if (it.operation == steq_pkg::OP_EXPIRE || it.operation == steq_pkg::OP_QUERY)
      clock_sec = clock_sec + 32'($urandom_range(0, 2));
    repeat (gap_len()) @(negedge clk);
    send_item(it);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty store answers, then field extremes
    send_op(steq_pkg::OP_QUERY, '0, '0, '0, '0, '0, '0);
    send_op(steq_pkg::OP_EXPIRE, '0, '0, '0, '0, 32'hffffffff, 20'hfffff);
    send_op(steq_pkg::OP_INSERT, 32'hffffffff, 20'hfffff, 8'hff, 16'hffff, '0, '0);
    send_op(steq_pkg::OP_INSERT, '0, '0, 8'h00, 16'h0000, '0, '0);
    send_op(steq_pkg::OP_INSERT, 32'd10, 20'd5, 8'h01, 16'h0000, '0, '0);
    // equal deadline keeps order
    send_op(steq_pkg::OP_INSERT, 32'd10, 20'd5, 8'h02, 16'h0000, '0, '0);
    send_op(steq_pkg::OP_INSERT, 32'd10, 20'd999999, 8'h03, 16'h0007, '0, '0);
    // earliest already due
    send_op(steq_pkg::OP_QUERY, '0, '0, '0, '0, '0, '0);
    send_op(steq_pkg::OP_EXPIRE, '0, '0, '0, '0, '0, '0);
    // borrow case
    send_op(steq_pkg::OP_QUERY, '0, '0, '0, '0, 32'd3, 20'd999999);
    // no borrow
    send_op(steq_pkg::OP_QUERY, '0, '0, '0, '0, 32'd3, 20'd1);
    send_op(steq_pkg::OP_QUERY, '0, '0, '0, '0, 32'hffffffff, 20'hfffff);
    send_op(steq_pkg::OP_RM_OWNKIND, '0, '0, 8'h02, 16'h0000, '0, '0);
    // owner zero is valid
    send_op(steq_pkg::OP_RM_OWNER, '0, '0, '0, 16'h0000, '0, '0);
    // nothing to remove
    send_op(steq_pkg::OP_RM_OWNER, '0, '0, '0, 16'h5555, '0, '0);
    // unknown codes
    send_op(OP_UNKNOWN_LO, '0, '0, '0, '0, '0, '0);
    send_op(OP_UNKNOWN_HI, '0, '0, '0, '0, '0, '0);
    // fill to capacity, the last few are refused, then expire them all at once
    for (int i = 0; i < steq_pkg::CAPACITY + 1; i++)
      send_op(steq_pkg::OP_INSERT, 32'd20, 20'(i * 7), 8'(i), 16'(i), '0, '0);
    send_op(steq_pkg::OP_EXPIRE, '0, '0, '0, '0, 32'hffffffff, 20'hfffff);
    send_op(steq_pkg::OP_EXPIRE, '0, '0, '0, '0, 32'hffffffff, 20'hfffff);
    drain();   // sender holds off until everything has come back

    for (int n = 0; n < 310; n++) begin
      send_random();
      if (n == 155) drain();
    end
    drain();
    repeat (200) @(posedge clk);
    if (board.errors == 0 && board.owed.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
